// ===== rtl/core/manowar_julia_escape_iteration_assert.svh =====
// assertion macros for the manowar julia escape iteration block
// no dependencies; each macro compiles to nothing when ASSERT_OFF is defined
`ifndef MANOWAR_JULIA_ESCAPE_ITERATION_ASSERT_SVH
`define MANOWAR_JULIA_ESCAPE_ITERATION_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, held off while reset is low
`define MJEI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication, held off while reset is low
`define MJEI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define MJEI_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MJEI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/mjei_pkg.sv =====
// shared types, constants and fixed-point helpers for the julia escape block
// no dependencies
`default_nettype none

package mjei_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 27;
    localparam int COUNT_BITS = 16;
    localparam int COLOR_BITS = COUNT_BITS + 1;
    localparam int PAL_BITS   = 16;

    localparam int IN_DATA_BITS  = ((2 * WORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((COUNT_BITS + COLOR_BITS + 7) / 8) * 8;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = WORD_BITS;

    localparam logic [CFG_ADDR_BITS-1:0] REG_CONST_RE   = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CONST_IM   = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_ITER   = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_COLOR_MODE = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PAL_SIZE   = 3'd4;

    localparam logic [COUNT_BITS-1:0] MAX_ITER_RST = COUNT_BITS'(256);
    localparam logic [PAL_BITS-1:0]   PAL_SIZE_RST = PAL_BITS'(256);

    localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // escape threshold 4.0 in the fixed-point format, one bit wider than a word
    localparam logic [WORD_BITS:0] FOUR_Q = (WORD_BITS+1)'(1) << (FRAC_BITS + 2);

    typedef logic signed [WORD_BITS-1:0]   t_word;
    typedef logic signed [2*WORD_BITS-1:0] t_dword;

    typedef struct packed {
        t_word                 const_re;
        t_word                 const_im;
        logic [COUNT_BITS-1:0] max_iter;
    } t_core_cfg;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic                  no_escape;
        t_word                 zr;
        t_word                 zi;
    } t_core_res;

    // clamp a double-width value to the word range
    function automatic t_word sat_word(input t_dword v);
        logic [WORD_BITS:0] upper;
        upper = v[2*WORD_BITS-1:WORD_BITS-1];
        if ((&upper) || !(|upper)) begin
            return v[WORD_BITS-1:0];
        end
        return v[2*WORD_BITS-1] ? WMIN : WMAX;
    endfunction

    // saturating word add
    function automatic t_word sat_add(input t_word a, input t_word b);
        logic [WORD_BITS:0] sum;
        sum = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (sum[WORD_BITS] != sum[WORD_BITS-1]) begin
            return sum[WORD_BITS] ? WMIN : WMAX;
        end
        return sum[WORD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mjei_mul.sv =====
// shared signed word multiplier with a registered full-width product
// depends on mjei_pkg
`default_nettype none

module mjei_mul
    import mjei_pkg::*;
(
    input  wire logic i_clk,
    input  wire t_word i_a,
    input  wire t_word i_b,
    output t_dword    o_prod
);

    t_dword r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= t_dword'(i_a) * t_dword'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== rtl/core/mjei_core.sv =====
// iteration sequencer: runs z' = z^2 + k + z_prev on the shared multiplier
// depends on mjei_pkg and mjei_mul
`default_nettype none

module mjei_core
    import mjei_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_start,
    input  wire t_word     i_point_re,
    input  wire t_word     i_point_im,
    input  wire t_core_cfg i_cfg,
    output logic           o_idle,
    output logic           o_res_valid,
    input  wire logic      i_res_ready,
    output t_core_res      o_res
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SQ_RE = 3'd1;
    localparam logic [2:0] S_SQ_IM = 3'd2;
    localparam logic [2:0] S_CROSS = 3'd3;
    localparam logic [2:0] S_UPD   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    t_word                 r_zr;
    t_word                 r_zi;
    t_word                 r_pr;
    t_word                 r_pi;
    t_word                 r_r2;
    t_word                 r_i2;
    logic [COUNT_BITS-1:0] r_n;
    logic                  r_inside;

    t_word  w_mul_a;
    t_word  w_mul_b;
    t_dword w_prod;
    t_word  w_sq;
    t_word  w_cross;
    t_word  w_nr;
    t_word  w_ni;
    logic   w_escape;
    logic   w_at_limit;

    // operand select for the shared multiplier
    always_comb begin
        unique case (r_state)
            S_SQ_IM: begin
                w_mul_a = r_zi;
                w_mul_b = r_zi;
            end
            S_CROSS: begin
                w_mul_a = r_zr;
                w_mul_b = r_zi;
            end
            default: begin
                w_mul_a = r_zr;
                w_mul_b = r_zr;
            end
        endcase
    end

    mjei_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // product arrives in the cycle after its operands
    assign w_sq       = sat_word(w_prod >>> FRAC_BITS);
    assign w_cross    = sat_word(w_prod >>> (FRAC_BITS - 1));
    assign w_escape   = ({1'b0, r_r2} + {1'b0, r_i2}) > FOUR_Q;
    assign w_ni       = sat_add(sat_add(w_cross, i_cfg.const_im), r_pi);
    assign w_nr       = sat_add(sat_add(r_r2 - r_i2, i_cfg.const_re), r_pr);
    assign w_at_limit = (r_n == i_cfg.max_iter);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) n_state = S_SQ_RE;
            S_SQ_RE: n_state = w_at_limit ? S_DONE : S_SQ_IM;
            S_SQ_IM: n_state = S_CROSS;
            S_CROSS: n_state = S_UPD;
            S_UPD:   n_state = w_escape ? S_DONE : S_SQ_RE;
            S_DONE:  if (i_res_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_zr     <= i_point_re;
                    r_zi     <= i_point_im;
                    r_pr     <= i_point_re;
                    r_pi     <= i_point_im;
                    r_n      <= '0;
                    r_inside <= 1'b1;
                end
            end
            S_SQ_IM: r_r2 <= w_sq;
            S_CROSS: r_i2 <= w_sq;
            S_UPD: begin
                if (w_escape) begin
                    r_inside <= 1'b0;
                end else begin
                    r_pr <= r_zr;
                    r_pi <= r_zi;
                    r_zr <= w_nr;
                    r_zi <= w_ni;
                    r_n  <= r_n + COUNT_BITS'(1);
                end
            end
            default: ;
        endcase
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = '{count: r_n, no_escape: r_inside, zr: r_zr, zi: r_zi};

endmodule

`default_nettype wire

// ===== rtl/core/manowar_julia_escape_iteration.sv =====
// channel   | dir | tdata (low bit up)                    | tuser
// s (point) | in  | point_re, point_im                    | -
// m (res)   | out | iteration_count, color, zero pad      | inside_res
// cfg       | in  | write enable, register index, data    | -
//
// one iteration steps through the states S_SQ_RE, S_SQ_IM, S_CROSS and S_UPD
// on the one shared multiplier
// reset is synchronous, active low; configuration returns to k = 0, limit 256,
// escape-time mode and palette 256
// the input side is ready only while the sequencer is idle; a finished beat
// waits in the output register and does not hold up taking the next point
// depends on mjei_pkg, mjei_mul and mjei_core
`default_nettype none

module manowar_julia_escape_iteration
    import mjei_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // point_re [31:0], point_im [63:32]
    input  wire logic [IN_DATA_BITS-1:0]  i_s_tdata,
    input  wire logic                     i_s_tvalid,
    output logic                          o_s_tready,
    // iteration_count [15:0], color [32:16], zeros above
    output logic [OUT_DATA_BITS-1:0]      o_m_tdata,
    // inside_res [0]
    output logic                          o_m_tuser,
    output logic                          o_m_tvalid,
    input  wire logic                     i_m_tready,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);

`include "manowar_julia_escape_iteration_assert.svh"

    t_word                 r_const_re;
    t_word                 r_const_im;
    logic [COUNT_BITS-1:0] r_max_iter;
    logic                  r_color_mode;
    logic [PAL_BITS-1:0]   r_pal_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_const_re   <= '0;
            r_const_im   <= '0;
            r_max_iter   <= MAX_ITER_RST;
            r_color_mode <= 1'b0;
            r_pal_size   <= PAL_SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_CONST_RE:   r_const_re   <= i_cfg_data[WORD_BITS-1:0];
                REG_CONST_IM:   r_const_im   <= i_cfg_data[WORD_BITS-1:0];
                REG_MAX_ITER:   r_max_iter   <= i_cfg_data[COUNT_BITS-1:0];
                REG_COLOR_MODE: r_color_mode <= i_cfg_data[0];
                REG_PAL_SIZE:   r_pal_size   <= i_cfg_data[PAL_BITS-1:0];
                default: ;
            endcase
        end
    end

    t_core_cfg w_cfg;
    t_core_res w_res;
    logic      w_idle;
    logic      w_res_valid;
    logic      w_res_ready;
    logic      w_start;

    assign w_cfg = '{const_re: r_const_re, const_im: r_const_im, max_iter: r_max_iter};

    assign o_s_tready = w_idle;
    assign w_start    = i_s_tvalid && w_idle;

    mjei_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_point_re  (i_s_tdata[WORD_BITS-1:0]),
        .i_point_im  (i_s_tdata[2*WORD_BITS-1:WORD_BITS]),
        .i_cfg       (w_cfg),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // quadrant offset of the final z for escape-angle colouring
    logic                  w_re_pos;
    logic                  w_im_pos;
    logic                  w_im_neg;
    logic [PAL_BITS+1:0]   w_pal3;
    logic [PAL_BITS-1:0]   w_offset;
    logic [COLOR_BITS-1:0] w_color;

    assign w_re_pos = !w_res.zr[WORD_BITS-1] && (|w_res.zr);
    assign w_im_pos = !w_res.zi[WORD_BITS-1] && (|w_res.zi);
    assign w_im_neg = w_res.zi[WORD_BITS-1];
    assign w_pal3   = (PAL_BITS+2)'(r_pal_size) * (PAL_BITS+2)'(3);

    always_comb begin
        if (w_re_pos && w_im_pos) begin
            w_offset = PAL_BITS'(1);
        end else if (!w_re_pos && w_im_pos) begin
            w_offset = {2'b00, r_pal_size[PAL_BITS-1:2]};
        end else if (!w_re_pos && w_im_neg) begin
            w_offset = {1'b0, r_pal_size[PAL_BITS-1:1]};
        end else begin
            w_offset = w_pal3[PAL_BITS+1:2];
        end
        w_color = COLOR_BITS'(w_res.count);
        if (r_color_mode) begin
            w_color = COLOR_BITS'(w_res.count) + COLOR_BITS'(w_offset);
        end
    end

    // output register
    logic                  r_out_valid;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_inside;
    logic [COLOR_BITS-1:0] r_color;

    assign w_res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_count  <= w_res.count;
            r_inside <= w_res.no_escape;
            r_color  <= w_color;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_inside;
    assign o_m_tdata  = OUT_DATA_BITS'({r_color, r_count});

    // the sequencer never takes a point while it holds a finished one
    `MJEI_ASSERT_NOW(a_start_not_done, i_clk, i_rst_n, w_start, !w_res_valid)
    // a taken point closes the input side on the next cycle
    `MJEI_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, w_start, !o_s_tready)
    // an inside beat has run to the full limit
    `MJEI_ASSERT_NOW(a_inside_at_limit, i_clk, i_rst_n, r_out_valid && r_inside,
        r_count == r_max_iter)
    // escape-time colour is the count itself
    `MJEI_ASSERT_NOW(a_time_color, i_clk, i_rst_n, r_out_valid && !r_color_mode,
        r_color == COLOR_BITS'(r_count))

endmodule

`default_nettype wire
